// ----- hw/rtl/nbma_pkg.sv -----
// Shared types, constants and micro-operation codes of the NTT base multiply accumulator.
`default_nettype none

package nbma_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int TW_WIDTH   = 12;
  localparam int RES_WIDTH  = 13;

  localparam int KQ            = 3329;
  localparam int KQINV         = -3327;
  localparam int BARRETT_V     = ((1 << 26) + KQ / 2) / KQ;
  localparam int BARRETT_ROUND = 1 << 9;
  localparam int MONT_R2       = int'((longint'(1) << 32) % longint'(KQ));

  typedef logic signed [COEF_WIDTH-1:0] coef_t;
  typedef logic signed [TW_WIDTH-1:0]   twiddle_t;
  typedef logic signed [RES_WIDTH-1:0]  res_t;

  // Micro-operations of the shared Montgomery multiplier.
  typedef logic [3:0] op_t;
  localparam op_t OP_A1B1 = 4'd0;   // a1*b1 into the temporary
  localparam op_t OP_T0Z  = 4'd1;   // temporary*zeta added to accumulator 0
  localparam op_t OP_A0B0 = 4'd2;   // added to accumulator 0
  localparam op_t OP_A0B1 = 4'd3;   // added to accumulator 1
  localparam op_t OP_A1B0 = 4'd4;   // added to accumulator 1
  localparam op_t OP_A3B3 = 4'd5;   // a3*b3 into the temporary
  localparam op_t OP_T2Z  = 4'd6;   // temporary*zeta subtracted from accumulator 2
  localparam op_t OP_A2B2 = 4'd7;   // added to accumulator 2
  localparam op_t OP_A2B3 = 4'd8;   // added to accumulator 3
  localparam op_t OP_A3B2 = 4'd9;   // added to accumulator 3
  localparam op_t OP_FIN  = 4'd10;  // temporary*R2 into a result register

  typedef struct packed {
    coef_t    a_c0;
    coef_t    a_c1;
    coef_t    a_c2;
    coef_t    a_c3;
    coef_t    b_c0;
    coef_t    b_c1;
    coef_t    b_c2;
    coef_t    b_c3;
    twiddle_t twiddle;
    logic     last_element;
  } item_t;

  typedef struct packed {
    res_t r_c0;
    res_t r_c1;
    res_t r_c2;
    res_t r_c3;
  } result_t;

  typedef struct packed {
    logic       capture;
    op_t        op;
    logic       mont_issue;
    logic       mont_wb;
    logic       bar_issue;
    logic       bar_wb;
    logic       bar_to_tmp;
    logic [1:0] idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic to_mont;
  } status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nbma_in_if.sv -----
// Input channel: valid/ready handshake carrying one coefficient group transaction.
`default_nettype none

interface nbma_in_if;
  import nbma_pkg::*;

  logic     valid;
  logic     ready;
  coef_t    a_c0;
  coef_t    a_c1;
  coef_t    a_c2;
  coef_t    a_c3;
  coef_t    b_c0;
  coef_t    b_c1;
  coef_t    b_c2;
  coef_t    b_c3;
  twiddle_t twiddle;
  logic     last_element;

  modport source (
    output valid, a_c0, a_c1, a_c2, a_c3, b_c0, b_c1, b_c2, b_c3, twiddle, last_element,
    input  ready
  );

  modport sink (
    input  valid, a_c0, a_c1, a_c2, a_c3, b_c0, b_c1, b_c2, b_c3, twiddle, last_element,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/nbma_out_if.sv -----
// Output channel: valid/ready handshake carrying one reduced coefficient group transaction.
`default_nettype none

interface nbma_out_if;
  import nbma_pkg::*;

  logic valid;
  logic ready;
  res_t r_c0;
  res_t r_c1;
  res_t r_c2;
  res_t r_c3;

  modport source (
    output valid, r_c0, r_c1, r_c2, r_c3,
    input  ready
  );

  modport sink (
    input  valid, r_c0, r_c1, r_c2, r_c3,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/nbma_dp.sv -----
// Datapath: operand registers, shared Montgomery multiplier, Barrett unit and accumulators.
`default_nettype none

module nbma_dp (
  input  logic              clk,
  input  logic              rst,
  input  nbma_pkg::cmd_t    cmd,
  output nbma_pkg::status_t status,
  input  nbma_pkg::item_t   item,
  output nbma_pkg::result_t result,
  input  logic              wr_en,
  input  logic              wr_data
);
  import nbma_pkg::*;

  localparam coef_t KQ_C    = COEF_WIDTH'(KQ);
  localparam coef_t KQINV_C = COEF_WIDTH'(KQINV);
  localparam coef_t BV_C    = COEF_WIDTH'(BARRETT_V);
  localparam coef_t ROUND_C = COEF_WIDTH'(BARRETT_ROUND);
  localparam coef_t R2_C    = COEF_WIDTH'(MONT_R2);

  coef_t    a [4];
  coef_t    b [4];
  twiddle_t z;
  logic     last;
  logic     to_mont;
  coef_t    acc [4];
  coef_t    tmp;
  res_t     res [4];
  res_t     out_c [4];

  // Montgomery multiplier pipeline.
  coef_t                        mx;
  coef_t                        my;
  coef_t                        z_ext;
  logic signed [2*COEF_WIDTH-1:0] prod_c;
  logic signed [2*COEF_WIDTH-1:0] m_prod;
  logic signed [2*COEF_WIDTH-1:0] u_full;
  logic signed [2*COEF_WIDTH-1:0] t_full;
  coef_t                        m_lo;
  coef_t                        m_u;
  coef_t                        m_hi;
  coef_t                        mres;

  // Barrett reduction.
  logic signed [2*COEF_WIDTH-1:0] b_prod;
  logic signed [2*COEF_WIDTH-1:0] thq;
  coef_t                        b_x;
  coef_t                        th1;
  coef_t                        th2;
  logic signed [5:0]            th3;
  coef_t                        bar_r;

  assign z_ext = COEF_WIDTH'(z);

  always_comb begin
    mx = '0;
    my = '0;
    case (cmd.op)
      OP_A1B1: begin
        mx = a[1];
        my = b[1];
      end
      OP_A0B0: begin
        mx = a[0];
        my = b[0];
      end
      OP_A0B1: begin
        mx = a[0];
        my = b[1];
      end
      OP_A1B0: begin
        mx = a[1];
        my = b[0];
      end
      OP_A3B3: begin
        mx = a[3];
        my = b[3];
      end
      OP_A2B2: begin
        mx = a[2];
        my = b[2];
      end
      OP_A2B3: begin
        mx = a[2];
        my = b[3];
      end
      OP_A3B2: begin
        mx = a[3];
        my = b[2];
      end
      OP_T0Z, OP_T2Z: begin
        mx = tmp;
        my = z_ext;
      end
      OP_FIN: begin
        mx = tmp;
        my = R2_C;
      end
      default: begin
      end
    endcase
  end

  assign prod_c = (2*COEF_WIDTH)'(mx) * (2*COEF_WIDTH)'(my);
  assign m_lo   = $signed(m_prod[COEF_WIDTH-1:0]);
  assign u_full = (2*COEF_WIDTH)'(m_lo) * (2*COEF_WIDTH)'(KQINV_C);
  assign t_full = (2*COEF_WIDTH)'(m_u) * (2*COEF_WIDTH)'(KQ_C);
  assign mres   = m_hi - $signed(t_full[2*COEF_WIDTH-1:COEF_WIDTH]);

  always_ff @(posedge clk) begin
    if (cmd.mont_issue) begin
      m_prod <= prod_c;
    end
    m_u  <= $signed(u_full[COEF_WIDTH-1:0]);
    m_hi <= $signed(m_prod[2*COEF_WIDTH-1:COEF_WIDTH]);
  end

  assign th1   = $signed(b_prod[2*COEF_WIDTH-1:COEF_WIDTH]);
  assign th2   = th1 + ROUND_C;
  assign th3   = $signed(th2[COEF_WIDTH-1:10]);
  assign thq   = (2*COEF_WIDTH)'(th3) * (2*COEF_WIDTH)'(KQ_C);
  assign bar_r = b_x - $signed(thq[COEF_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.bar_issue) begin
      b_prod <= (2*COEF_WIDTH)'(acc[cmd.idx]) * (2*COEF_WIDTH)'(BV_C);
      b_x    <= acc[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      a[0] <= item.a_c0;
      a[1] <= item.a_c1;
      a[2] <= item.a_c2;
      a[3] <= item.a_c3;
      b[0] <= item.b_c0;
      b[1] <= item.b_c1;
      b[2] <= item.b_c2;
      b[3] <= item.b_c3;
      z    <= item.twiddle;
      last <= item.last_element;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      to_mont <= 1'b0;
    end else if (wr_en) begin
      to_mont <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= '0;
      end
    end else if (cmd.load_out) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= '0;
      end
    end else if (cmd.mont_wb) begin
      case (cmd.op)
        OP_T0Z, OP_A0B0: acc[0] <= acc[0] + mres;
        OP_A0B1, OP_A1B0: acc[1] <= acc[1] + mres;
        OP_T2Z: acc[2] <= acc[2] - mres;
        OP_A2B2: acc[2] <= acc[2] + mres;
        OP_A2B3, OP_A3B2: acc[3] <= acc[3] + mres;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mont_wb) begin
      case (cmd.op)
        OP_A1B1, OP_A3B3: tmp <= mres;
        OP_FIN: res[cmd.idx] <= $signed(mres[RES_WIDTH-1:0]);
        default: begin
        end
      endcase
    end else if (cmd.bar_wb) begin
      if (cmd.bar_to_tmp) begin
        tmp <= bar_r;
      end else begin
        res[cmd.idx] <= $signed(bar_r[RES_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int k = 0; k < 4; k++) begin
        out_c[k] <= res[k];
      end
    end
  end

  assign result.r_c0 = out_c[0];
  assign result.r_c1 = out_c[1];
  assign result.r_c2 = out_c[2];
  assign result.r_c3 = out_c[3];

  assign status.last    = last;
  assign status.to_mont = to_mont;

endmodule

`default_nettype wire

// ----- hw/rtl/nbma_ctrl.sv -----
// Controller: sequences the ten products, the final reduction and the output handshake.
`default_nettype none

module nbma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nbma_pkg::status_t status,
  output nbma_pkg::cmd_t    cmd
);
  import nbma_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_BAR  = 3'd2;
  localparam logic [2:0] S_FMUL = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [1:0] PH_ISSUE = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_WB    = 2'd2;

  localparam logic [1:0] LAST_IDX = 2'd3;

  logic [2:0] state;
  logic [1:0] phase;
  op_t        op;
  logic [1:0] idx;
  logic       mul_state;

  assign mul_state = (state == S_MUL) || (state == S_FMUL);

  always_comb begin
    cmd            = '0;
    in_ready       = (state == S_IDLE);
    cmd.capture    = in_valid && in_ready;
    cmd.op         = (state == S_FMUL) ? OP_FIN : op;
    cmd.idx        = idx;
    cmd.mont_issue = mul_state && (phase == PH_ISSUE);
    cmd.mont_wb    = mul_state && (phase == PH_WB);
    cmd.bar_issue  = (state == S_BAR) && (phase == PH_ISSUE);
    cmd.bar_wb     = (state == S_BAR) && (phase == PH_WAIT);
    cmd.bar_to_tmp = status.to_mont;
    cmd.load_out   = (state == S_EMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_ISSUE;
      op        <= OP_A1B1;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.capture) begin
            state <= S_MUL;
            phase <= PH_ISSUE;
            op    <= OP_A1B1;
          end
        end
        S_MUL: begin
          case (phase)
            PH_ISSUE: phase <= PH_WAIT;
            PH_WAIT:  phase <= PH_WB;
            PH_WB: begin
              phase <= PH_ISSUE;
              if (op == OP_A3B2) begin
                idx   <= '0;
                state <= status.last ? S_BAR : S_IDLE;
              end else begin
                op <= op + 1'b1;
              end
            end
            default: phase <= PH_ISSUE;
          endcase
        end
        S_BAR: begin
          case (phase)
            PH_ISSUE: phase <= PH_WAIT;
            PH_WAIT: begin
              phase <= PH_ISSUE;
              if (status.to_mont) begin
                state <= S_FMUL;
              end else if (idx == LAST_IDX) begin
                state <= S_EMIT;
              end else begin
                idx <= idx + 1'b1;
              end
            end
            default: phase <= PH_ISSUE;
          endcase
        end
        S_FMUL: begin
          case (phase)
            PH_ISSUE: phase <= PH_WAIT;
            PH_WAIT:  phase <= PH_WB;
            PH_WB: begin
              phase <= PH_ISSUE;
              if (idx == LAST_IDX) begin
                state <= S_EMIT;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_BAR;
              end
            end
            default: phase <= PH_ISSUE;
          endcase
        end
        S_EMIT: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ntt_basemul_accumulate.sv -----
// Top level of the Kyber NTT-domain base multiply and accumulate block.
// Usage:
//   The operands channel takes one transaction per coefficient group of one vector
//   element: four coefficients each of a and b plus the group's Montgomery-form zeta.
//   Its products are added into four 16-bit wrapping accumulators. A transaction with
//   last_element set is followed by rounding Barrett reduction of each accumulator,
//   optionally a Montgomery multiply by 2^32 mod q (wr_en/wr_data set to_montgomery),
//   and one transaction on the results channel; the accumulators then clear.
// Sequencing:
//   One Montgomery multiplier is shared by all ten products of a transaction; each
//   product passes through issue, wait and write-back phases, and a new transaction
//   is accepted only once the block has finished the last one. The closing reduction
//   takes each coefficient in turn through Barrett issue and write-back, then with
//   to_montgomery set a multiply by 2^32 mod q; the output register loads last.
// Stalls and reset:
//   The result sits in an output register, so a new operand transaction is accepted
//   while the receiver stalls; the block only waits when the next result is ready
//   to load and the previous one has not been taken yet. Reset (synchronous, active
//   high) clears the accumulators, to_montgomery and all handshake state. The user
//   must write configuration only while the block is idle; the block does not check.
`default_nettype none

module ntt_basemul_accumulate (
  input logic         clk,
  input logic         rst,
  nbma_in_if.sink     operands,
  nbma_out_if.source  results,
  input logic         wr_en,
  input logic         wr_data
);
  import nbma_pkg::*;

  cmd_t    cmd;
  status_t status;
  item_t   item;
  result_t result;
  logic    out_valid;
  logic    in_ready;

  // Gather the operand fields into one bundle for the datapath.
  assign item.a_c0         = operands.a_c0;
  assign item.a_c1         = operands.a_c1;
  assign item.a_c2         = operands.a_c2;
  assign item.a_c3         = operands.a_c3;
  assign item.b_c0         = operands.b_c0;
  assign item.b_c1         = operands.b_c1;
  assign item.b_c2         = operands.b_c2;
  assign item.b_c3         = operands.b_c3;
  assign item.twiddle      = operands.twiddle;
  assign item.last_element = operands.last_element;

  assign operands.ready = in_ready;

  // The controller owns the handshakes, the datapath owns every payload bit.
  nbma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  nbma_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .item    (item),
    .result  (result),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  assign results.valid = out_valid;
  assign results.r_c0  = result.r_c0;
  assign results.r_c1  = result.r_c1;
  assign results.r_c2  = result.r_c2;
  assign results.r_c3  = result.r_c3;

endmodule

`default_nettype wire

// ----- bench/ntt_basemul_accumulate_tb.sv -----
// Self-checking testbench of the NTT base multiply accumulator: directed table, random vectors.
`default_nettype none

module ntt_basemul_accumulate_tb;
  import nbma_pkg::*;

  // Arithmetic constants of the Kyber field, kept local to the predictor.
  localparam int Q_MOD     = 3329;
  localparam int Q_NEG_INV = -3327;                         // q^-1 mod 2^16
  localparam int BAR_MULT  = ((1 << 26) + Q_MOD / 2) / Q_MOD;
  localparam int BAR_HALF  = 1 << 9;
  localparam int R2_MOD    = 1353;                          // 2^32 mod q

  // Cycles after the final result before the block is taken as idle.
  localparam int DRAIN_CYCLES = 64;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    item_t   grp;
    bit      pinned;   // expected result typed in below instead of predicted
    result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic wr_data;

  nbma_in_if  operands_ch ();
  nbma_out_if results_ch ();

  ntt_basemul_accumulate dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operands_ch),
    .results  (results_ch),
    .wr_en    (wr_en),
    .wr_data  (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: the four running sums and the to_montgomery setting.
  int      acc_sum [4];
  bit      mont_on;
  // Reduced groups still owed by the block, oldest first.
  result_t reduced_groups [$];
  stim_row_t directed_rows [$];

  int      mismatches;
  int      idle_cycles;
  int      sink_hold;
  bit      sink_calm;
  result_t head_want;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Two's-complement wrap to 16 bits, returned sign-extended.
  function automatic int wrap16(input int x);
    logic signed [15:0] t;
    t = x[15:0];
    return int'(t);
  endfunction

  // Signed Montgomery product x*y*2^-16 mod q, with the low and high halves
  // wrapping to 16 bits as the hardware does.
  function automatic int mont_product(input int x, input int y);
    int p;
    int m;
    p = x * y;
    m = wrap16(wrap16(p) * Q_NEG_INV);
    return wrap16((p >>> 16) - ((m * Q_MOD) >>> 16));
  endfunction

  // Rounding Barrett reduction of a 16-bit value.
  function automatic int barrett_fold(input int x);
    int est;
    est = (x * BAR_MULT) >>> 16;
    est = wrap16(est + BAR_HALF) >>> 10;
    return wrap16(x - est * Q_MOD);
  endfunction

  // Adds one group's base products into the running sums. On the closing
  // element it reduces the sums into a result, clears them and returns 1.
  function automatic bit basemul_accumulate(input item_t grp, output result_t sum);
    int a0, a1, a2, a3, b0, b1, b2, b3, z;
    int prod [4];
    int red [4];
    a0 = $signed(grp.a_c0);
    a1 = $signed(grp.a_c1);
    a2 = $signed(grp.a_c2);
    a3 = $signed(grp.a_c3);
    b0 = $signed(grp.b_c0);
    b1 = $signed(grp.b_c1);
    b2 = $signed(grp.b_c2);
    b3 = $signed(grp.b_c3);
    z  = $signed(grp.twiddle);
    // First pair modulo X^2 - zeta, second pair modulo X^2 + zeta.
    prod[0] = mont_product(mont_product(a1, b1), z) + mont_product(a0, b0);
    prod[1] = mont_product(a0, b1) + mont_product(a1, b0);
    prod[2] = mont_product(a2, b2) - mont_product(mont_product(a3, b3), z);
    prod[3] = mont_product(a2, b3) + mont_product(a3, b2);
    for (int k = 0; k < 4; k++) acc_sum[k] = wrap16(acc_sum[k] + prod[k]);
    sum = '0;
    if (!grp.last_element) return 1'b0;
    for (int k = 0; k < 4; k++) begin
      red[k] = barrett_fold(acc_sum[k]);
      if (mont_on) red[k] = mont_product(red[k], R2_MOD);
      acc_sum[k] = 0;
    end
    sum.r_c0 = red[0][12:0];
    sum.r_c1 = red[1][12:0];
    sum.r_c2 = red[2][12:0];
    sum.r_c3 = red[3][12:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t stim_row(input int a0, input int a1, input int a2,
                                         input int a3, input int b0, input int b1,
                                         input int b2, input int b3, input int z,
                                         input bit last, input bit pinned);
    stim_row_t r;
    r.grp.a_c0 = a0[15:0];
    r.grp.a_c1 = a1[15:0];
    r.grp.a_c2 = a2[15:0];
    r.grp.a_c3 = a3[15:0];
    r.grp.b_c0 = b0[15:0];
    r.grp.b_c1 = b1[15:0];
    r.grp.b_c2 = b2[15:0];
    r.grp.b_c3 = b3[15:0];
    r.grp.twiddle = z[11:0];
    r.grp.last_element = last;
    r.pinned = pinned;
    // Every pinned row below closes on an all-zero sum, which reduces to zero.
    r.want = '0;
    return r;
  endfunction

  // Idle length: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Coefficients: half full-range noise, the rest reduced values or extremes.
  function automatic coef_t rand_coef();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 50) v = $urandom;
    else if (pick < 85) v = int'($urandom_range(0, 6656)) - 3328;
    else begin
      case ($urandom_range(0, 4))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end
    return v[15:0];
  endfunction

  function automatic item_t rand_group(input bit last);
    item_t g;
    int z;
    g.a_c0 = rand_coef();
    g.a_c1 = rand_coef();
    g.a_c2 = rand_coef();
    g.a_c3 = rand_coef();
    g.b_c0 = rand_coef();
    g.b_c1 = rand_coef();
    g.b_c2 = rand_coef();
    g.b_c3 = rand_coef();
    // Mostly legal twiddles, sometimes any 12-bit pattern.
    if ($urandom_range(0, 6) == 0) z = $urandom;
    else z = int'($urandom_range(0, 3328)) - 1664;
    g.twiddle = z[11:0];
    g.last_element = last;
    return g;
  endfunction

  // Presents one coefficient group after an idle gap and returns at the edge
  // where the transaction is taken. Valid stays high when the next group follows
  // without a gap, so it is never lowered and raised within one step.
  task automatic send_group(input item_t grp, input int gap, input bit pinned,
                            input result_t pinned_want);
    result_t sum;
    bit      emitted;
    if (gap > 0) begin
      operands_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operands_ch.valid        <= 1'b1;
    operands_ch.a_c0         <= grp.a_c0;
    operands_ch.a_c1         <= grp.a_c1;
    operands_ch.a_c2         <= grp.a_c2;
    operands_ch.a_c3         <= grp.a_c3;
    operands_ch.b_c0         <= grp.b_c0;
    operands_ch.b_c1         <= grp.b_c1;
    operands_ch.b_c2         <= grp.b_c2;
    operands_ch.b_c3         <= grp.b_c3;
    operands_ch.twiddle      <= grp.twiddle;
    operands_ch.last_element <= grp.last_element;
    @(posedge clk);
    while (!operands_ch.ready) @(posedge clk);
    emitted = basemul_accumulate(grp, sum);
    if (emitted) reduced_groups.push_back(pinned ? pinned_want : sum);
  endtask

  // Waits until every owed result has been taken, then lets the block finish
  // any work still in flight before the next register write or the verdict.
  task automatic settle();
    operands_ch.valid <= 1'b0;
    while (reduced_groups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit v);
    wr_en   <= 1'b1;
    wr_data <= v;
    @(posedge clk);
    wr_en   <= 1'b0;
    mont_on = v;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("ntt_basemul_accumulate_tb: mismatch on %s at %0t: got %0d, expected %0d",
             what, $realtime, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, and the checker.
  // ---------------------------------------------------------------------------

  // The receiver stalls at random unless the current stretch is a calm one.
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      results_ch.ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (!sink_calm && $urandom_range(0, 2) == 0) begin
      results_ch.ready <= 1'b0;
      sink_hold <= pick_gap();
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // Every result transaction is compared field by field with the oldest group
  // still owed.
  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (reduced_groups.size() == 0) begin
        flag_mismatch("result with nothing owed", 0, 0);
      end else begin
        head_want = reduced_groups.pop_front();
        if (results_ch.r_c0 !== head_want.r_c0)
          flag_mismatch("r_c0", results_ch.r_c0, head_want.r_c0);
        if (results_ch.r_c1 !== head_want.r_c1)
          flag_mismatch("r_c1", results_ch.r_c1, head_want.r_c1);
        if (results_ch.r_c2 !== head_want.r_c2)
          flag_mismatch("r_c2", results_ch.r_c2, head_want.r_c2);
        if (results_ch.r_c3 !== head_want.r_c3)
          flag_mismatch("r_c3", results_ch.r_c3, head_want.r_c3);
      end
    end
  end

  // Watchdog: a long run of cycles with no transaction on either channel means
  // the block hung or a result never came.
  always @(posedge clk) begin
    if (rst || (operands_ch.valid && operands_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ntt_basemul_accumulate_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int      sent;
    int      len;
    bit      src_calm;
    result_t none;

    none = '0;
    mismatches = 0;
    idle_cycles = 0;
    sink_hold = 0;
    sink_calm = 1'b0;
    mont_on = 1'b0;
    for (int k = 0; k < 4; k++) acc_sum[k] = 0;

    rst = 1'b1;
    wr_en = 1'b0;
    wr_data = 1'b0;
    results_ch.ready = 1'b0;
    operands_ch.valid = 1'b0;
    operands_ch.a_c0 = '0;
    operands_ch.a_c1 = '0;
    operands_ch.a_c2 = '0;
    operands_ch.a_c3 = '0;
    operands_ch.b_c0 = '0;
    operands_ch.b_c1 = '0;
    operands_ch.b_c2 = '0;
    operands_ch.b_c3 = '0;
    operands_ch.twiddle = '0;
    operands_ch.last_element = 1'b0;

    // Directed table, run with to_montgomery clear. Pinned rows close on sums
    // that are zero by inspection: straight after reset, with a or b zero, and
    // right after an emit, which must have cleared the sums.
    // Each row: a_c0..a_c3 on the first line, then b_c0..b_c3, zeta, last, pinned.
    directed_rows.push_back(stim_row(     0,      0,      0,      0,
                                          0,      0,      0,      0,     0, 1, 1));
    directed_rows.push_back(stim_row(     0,      0,      0,      0,
                                     -32768, -32768, -32768, -32768,  1664, 1, 1));
    directed_rows.push_back(stim_row( 32767,  32767,  32767,  32767,
                                          0,      0,      0,      0, -1664, 1, 1));
    // Zeta patterns outside the legal range are taken as 12-bit signed values.
    directed_rows.push_back(stim_row(-32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -2048, 0, 0));
    directed_rows.push_back(stim_row( 32767, -32768,  32767, -32768,
                                     -32768,  32767, -32768,  32767,  2047, 1, 0));
    // Four large elements in a row push the 16-bit sums past their range.
    directed_rows.push_back(stim_row( 32767,  32767,  32767,  32767,
                                      32767,  32767,  32767,  32767,  1664, 0, 0));
    directed_rows.push_back(stim_row( 32767,  32767,  32767,  32767,
                                      32767,  32767,  32767,  32767,  1664, 0, 0));
    directed_rows.push_back(stim_row( 32767,  32767,  32767,  32767,
                                      32767,  32767,  32767,  32767,  1664, 0, 0));
    directed_rows.push_back(stim_row( 32767,  32767,  32767,  32767,
                                      32767,  32767,  32767,  32767,  1664, 1, 0));
    directed_rows.push_back(stim_row(     0,      0,      0,      0,
                                          0,      0,      0,      0,     0, 1, 1));
    directed_rows.push_back(stim_row(     1,      2,      3,      4,
                                          5,      6,      7,      8,    17, 1, 0));
    directed_rows.push_back(stim_row( -3328,  -3328,  -3328,  -3328,
                                       3328,   3328,   3328,   3328, -1664, 1, 0));
    directed_rows.push_back(stim_row(  1234,  -2345,   3100,  -3001,
                                       -777,   2900,  -1500,   2222,     0, 1, 0));
    directed_rows.push_back(stim_row('h5555, 'h5555, 'h5555, 'h5555,
                                     'hAAAA, 'hAAAA, 'hAAAA, 'hAAAA, 'h555, 1, 0));
    directed_rows.push_back(stim_row('hAAAA, 'hAAAA, 'hAAAA, 'hAAAA,
                                     'h5555, 'h5555, 'h5555, 'h5555, 'hAAA, 1, 0));
    // A three-element vector of moderate values.
    directed_rows.push_back(stim_row(   100,   -200,    300,   -400,
                                        500,   -600,    700,   -800,   555, 0, 0));
    directed_rows.push_back(stim_row(  -900,   1000,  -1100,   1200,
                                      -1300,   1400,  -1500,   1600,   555, 0, 0));
    directed_rows.push_back(stim_row(  1700,  -1800,   1900,  -2000,
                                       2100,  -2200,   2300,  -2400,   555, 1, 0));
    directed_rows.push_back(stim_row(     0,      0,      0,      0,
                                          0,      0,      0,      0,     0, 1, 1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The register is written even at its reset value so both settings are
    // reached through the port.
    write_mode(1'b0);
    foreach (directed_rows[i])
      send_group(directed_rows[i].grp, pick_gap(), directed_rows[i].pinned,
                 directed_rows[i].want);
    settle();

    // Random phases alternate to_montgomery. Each phase is built from whole
    // vectors, mostly of one to four elements with now and then a long one to make the
    // sums wrap, so every phase ends on a closing element with the sums clear.
    for (int phase = 0; phase < 4; phase++) begin
      write_mode(phase % 2 == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(5, 12);
        else len = $urandom_range(1, 4);
        // Some vectors run with no idling on one or both sides.
        src_calm = ($urandom_range(0, 4) == 0);
        sink_calm <= ($urandom_range(0, 4) == 0);
        for (int e = 0; e < len; e++) begin
          send_group(rand_group(e == len - 1), src_calm ? 0 : pick_gap(), 1'b0, none);
          sent++;
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("ntt_basemul_accumulate_tb: done, clean");
    end else begin
      $display("ntt_basemul_accumulate_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/nbma_pkg.sv
hw/rtl/nbma_in_if.sv
hw/rtl/nbma_out_if.sv
hw/rtl/nbma_dp.sv
hw/rtl/nbma_ctrl.sv
hw/rtl/ntt_basemul_accumulate.sv
bench/ntt_basemul_accumulate_tb.sv
